FILE: rtl/core/prq_pkg.sv
// Package for the policy request queue: codes, payload and entry types,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package prq_pkg;

  // Function codes of an input item
  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  // Ordering policies
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SFNF = 2'd1;
  localparam logic [1:0] POL_SFF  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POLICY   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam int unsigned CfgDataW = 5;

  typedef struct packed {
    logic        func;
    logic [15:0] request_tag;
    logic [12:0] name_length;
    logic [31:0] file_size;
  } item_t;

  typedef struct packed {
    logic [15:0] request_tag;
    logic [12:0] name_length;
    logic [31:0] file_size;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] popped_tag;
    logic [4:0]  occupancy;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic decide;
    logic append;
    logic scan_start;
    logic scan_step;
    logic tail;
    logic pop_read;
    logic pop_take;
    logic rsp_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic sorted;
    logic scan_last;
    logic rsp_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/prq_if.sv
// Valid/ready channel interfaces for the request and result sides of the
// policy request queue. No dependencies.
`default_nettype none

interface prq_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] request_tag;
  logic [12:0] name_length;
  logic [31:0] file_size;

  modport source (output valid, func, request_tag, name_length, file_size, input ready);
  modport sink   (input valid, func, request_tag, name_length, file_size, output ready);
endinterface

interface prq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] popped_tag;
  logic [4:0]  occupancy;

  modport source (output valid, status, popped_tag, occupancy, input ready);
  modport sink   (input valid, status, popped_tag, occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prq_ctrl.sv
// Controller of the policy request queue: sequences decide, scan, tail
// write, pop and result load. Depends on prq_pkg.
`default_nettype none

module prq_ctrl
  import prq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.is_push) begin
          if (sts_i.full) begin
            state_d = S_DONE;
          end else if (sts_i.sorted) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.append = 1'b1;
            state_d      = S_DONE;
          end
        end else if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop_take = 1'b1;
        state_d        = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.rsp_busy) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/prq_datapath.sv
// Datapath of the policy request queue: configuration registers, circular
// entry memory, ordered-insert scan with carry, and the result register.
// Depends on prq_pkg.
`default_nettype none

module prq_datapath
  import prq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_idx_i,
  input  wire [CfgDataW-1:0]   cfg_data_i,
  input  item_t                item_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire                  rsp_ready_i,
  output logic                 rsp_valid_o,
  output result_t              rsp_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [1:0]       pol_q;
  logic [4:0]       cap_q;
  item_t            item_q;
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] head_q;
  logic [CntW-1:0]  rd_idx_q;
  logic [CntW-1:0]  wr_idx_q;
  logic             found_q;
  entry_t           carry_q;
  entry_t           rd_data_q;
  logic [1:0]       status_q;
  logic [15:0]      tag_q;
  result_t          rsp_q;
  logic             rsp_valid_q;

  entry_t           mem [DEPTH];

  entry_t           new_entry;
  logic             less;
  logic             more;
  logic             full;
  logic             empty;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  // Logical slot to memory address, wrapping around the head
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [CntW-1:0]  idx);
    logic [AddrW:0] sum;
    sum = {1'b0, head} + (AddrW + 1)'(idx);
    if (sum >= (AddrW + 1)'(DEPTH)) begin
      sum = sum - (AddrW + 1)'(DEPTH);
    end
    return sum[AddrW-1:0];
  endfunction

  function automatic logic [31:0] key_of(input entry_t e, input logic [1:0] pol);
    return (pol == POL_SFNF) ? 32'(e.name_length) : e.file_size;
  endfunction

  assign new_entry = '{request_tag: item_q.request_tag,
                       name_length: item_q.name_length,
                       file_size:   item_q.file_size};
  assign less  = key_of(new_entry, pol_q) < key_of(rd_data_q, pol_q);
  assign more  = rd_idx_q < cnt_q;
  assign full  = (32'(cnt_q) >= 32'(cap_q)) || (32'(cnt_q) >= 32'(DEPTH));
  assign empty = (cnt_q == '0);

  // Status toward the controller
  always_comb begin
    sts_o           = '0;
    sts_o.is_push   = (item_q.func == FN_PUSH);
    sts_o.full      = full;
    sts_o.empty     = empty;
    sts_o.sorted    = ((pol_q == POL_SFNF) || (pol_q == POL_SFF)) && !empty;
    sts_o.scan_last = (wr_idx_q == (cnt_q - CntW'(1)));
    sts_o.rsp_busy  = rsp_valid_q && !rsp_ready_i;
  end

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head_q, cnt_q);
    wr_data = new_entry;
    rd_en   = 1'b0;
    rd_addr = head_q;
    if (cmd_i.append) begin
      wr_en = 1'b1;
    end
    if (cmd_i.tail) begin
      wr_en   = 1'b1;
      wr_data = found_q ? carry_q : new_entry;
    end
    if (cmd_i.scan_step) begin
      wr_addr = phys(head_q, wr_idx_q);
      if (found_q) begin
        wr_en   = 1'b1;
        wr_data = carry_q;
      end else if (less) begin
        wr_en = 1'b1;
      end
      rd_en   = more;
      rd_addr = phys(head_q, rd_idx_q);
    end
    if (cmd_i.pop_read || cmd_i.scan_start) begin
      rd_en = 1'b1;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Payload registers: latched item, scan carry and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.scan_step && (found_q || less)) begin
      carry_q <= rd_data_q;
    end
    if (cmd_i.rsp_load) begin
      rsp_q <= '{status: status_q, popped_tag: tag_q, occupancy: 5'(cnt_q)};
    end
  end

  // Control and queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q       <= POL_FIFO;
      cap_q       <= 5'd16;
      cnt_q       <= '0;
      head_q      <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      found_q     <= 1'b0;
      status_q    <= ST_OK;
      tag_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POLICY) begin
          pol_q <= cfg_data_i[1:0];
        end else begin
          cap_q <= cfg_data_i[4:0];
        end
      end
      if (cmd_i.decide) begin
        tag_q <= '0;
        if (item_q.func == FN_PUSH) begin
          status_q <= full ? ST_FULL : ST_OK;
        end else begin
          status_q <= empty ? ST_EMPTY : ST_OK;
        end
      end
      if (cmd_i.append || cmd_i.tail) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.pop_take) begin
        tag_q  <= rd_data_q.request_tag;
        head_q <= phys(head_q, CntW'(1));
        cnt_q  <= cnt_q - CntW'(1);
      end
      if (cmd_i.scan_start) begin
        rd_idx_q <= CntW'(1);
        wr_idx_q <= '0;
        found_q  <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (more) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
        wr_idx_q <= wr_idx_q + CntW'(1);
        if (less) begin
          found_q <= 1'b1;
        end
      end
      // Hold the result until its transfer
      if (cmd_i.rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/policy_request_queue.sv
// Policy request queue: bounded queue with FIFO, shortest-name-first and
// smallest-file-first insertion. Top level; depends on prq_pkg, prq_if,
// prq_ctrl and prq_datapath.
//
// Usage:
//   req_i carries one item (push or pop) per transfer; rsp_o returns one
//   result per item (status, popped tag, occupancy) in item order.
//   The block handles one item at a time. A rejected push, an empty pop or a
//   push under arrival order goes straight to the result; a pop reads the
//   head entry and then takes it; a push under a sorting policy with entries
//   held scans forward through the single-read-port entry memory (one entry
//   per cycle, shifting later entries by one through a carry register) and
//   writes the tail. The next request is taken only back in idle.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are to go in only
//   while the block is idle; the block does not enforce this. Index 0 is
//   the policy, index 1 the capacity.
//   Reset empties the queue, sets policy to arrival order and capacity to 16.
//   The result register holds while rsp_o.ready is low; a new request is
//   still taken, and its result waits for the held one to transfer.
`default_nettype none

module policy_request_queue
  import prq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_data_i,
  prq_req_if.sink            req_i,
  prq_rsp_if.source          rsp_o
);

  item_t   item;
  cmd_t    cmd;
  sts_t    sts;
  result_t rsp_data;
  logic    rsp_valid;
  logic    req_ready;

  // Gather the request payload
  assign item = '{func:        req_i.func,
                  request_tag: req_i.request_tag,
                  name_length: req_i.name_length,
                  file_size:   req_i.file_size};

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  prq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_data)
  );

  assign req_i.ready      = req_ready;
  assign rsp_o.valid      = rsp_valid;
  assign rsp_o.status     = rsp_data.status;
  assign rsp_o.popped_tag = rsp_data.popped_tag;
  assign rsp_o.occupancy  = rsp_data.occupancy;

  // At most one memory or sequencing action per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.latch, cmd.append, cmd.scan_start, cmd.scan_step, cmd.tail,
              cmd.pop_read, cmd.pop_take, cmd.rsp_load}))
    else $error("prq: conflicting commands");

  // A loaded result is offered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rsp_load |=> rsp_o.valid)
    else $error("prq: loaded result not offered");

  // No new request is taken while one is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("prq: request taken while busy");

  // Hold a stalled result until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_data)))
    else $error("prq: stalled result changed");

endmodule

`default_nettype wire
